// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// shared types, constants and helpers of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS = 8;                 // fractional bits of the operands
    localparam int QBITS     = 17;                // quotient magnitude bits kept
    localparam int DENW      = 32;                // |b|^2 width
    localparam int RW        = DENW + QBITS;      // divider remainder width
    localparam int ROOTW     = 16;                // root bits
    localparam int SRW       = 2 * ROOTW + 2;     // root remainder width
    localparam int NSTEP     = QBITS;             // iteration stages

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_MUL = 2'd1,
        MODE_DIV = 2'd2,
        MODE_MAG = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        fix_re;   // clipped add or multiply result
        logic [15:0]        fix_im;
        logic               fix_sat;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [RW-1:0]      rem_re;
        logic [RW-1:0]      rem_im;
        logic [QBITS-1:0]   q_re;
        logic [QBITS-1:0]   q_im;
        logic [DENW-1:0]    den;
        logic [SRW-1:0]     sq_rem;
        logic [ROOTW-1:0]   root;
    } t_pipe;

    // returns {clipped, value}
    function automatic logic [16:0] clip16(input logic signed [33:0] v);
        logic [16:0] r;
        if (v > 34'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -34'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // signed quotient from magnitude, sign and overflow, returns {clipped, value}
    function automatic logic [16:0] div_fix(input logic [QBITS-1:0] q, input logic neg,
                                            input logic ovf);
        logic [16:0] r;
        if (!neg && (ovf || q > QBITS'(32767))) begin
            r = {1'b1, 16'h7fff};
        end else if (neg && (ovf || q > QBITS'(32768))) begin
            r = {1'b1, 16'h8000};
        end else if (neg) begin
            r = {1'b0, 16'(-q)};
        end else begin
            r = {1'b0, q[15:0]};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_if
// operand and result channels of the complex arithmetic unit
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               div_zero;
    logic               saturated;
    modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
    modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

// ===== hw/rtl/cau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// products, sums and divider setup: three register stages
// ----------------------------------------------------------------------------
module cau_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic               o_valid,
    output cau_pkg::t_pipe     o_pipe
);
    import cau_pkg::*;

    // stage 0: products and add sums
    logic               r_s0_v;
    t_mode              r_s0_mode;
    logic signed [31:0] r_rr, r_ii, r_ir, r_ri, r_aa_r, r_aa_i, r_bb_r, r_bb_i;
    logic signed [16:0] r_add_re, r_add_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (i_ce) begin
            r_s0_v <= i_valid;
        end
        if (i_ce) begin
            r_s0_mode <= t_mode'(i_mode);
            r_rr      <= i_a_re * i_b_re;
            r_ii      <= i_a_im * i_b_im;
            r_ir      <= i_a_im * i_b_re;
            r_ri      <= i_a_re * i_b_im;
            r_aa_r    <= i_a_re * i_a_re;
            r_aa_i    <= i_a_im * i_a_im;
            r_bb_r    <= i_b_re * i_b_re;
            r_bb_i    <= i_b_im * i_b_im;
            r_add_re  <= 17'(i_a_re) + 17'(i_b_re);
            r_add_im  <= 17'(i_a_im) + 17'(i_b_im);
        end
    end

    // stage 1: sums, clipping of add and multiply, divider operands
    logic signed [32:0] mre, mim, nre, nim, mre_sh, mim_sh;
    logic [32:0]        nre_abs, nim_abs;
    logic [16:0]        c_re, c_im;
    t_pipe              n_s1;
    logic               r_s1_v;
    t_pipe              r_s1;

    always_comb begin
        mre     = 33'(r_rr) - 33'(r_ii);
        mim     = 33'(r_ir) + 33'(r_ri);
        nre     = 33'(r_rr) + 33'(r_ii);
        nim     = 33'(r_ir) - 33'(r_ri);
        mre_sh  = mre >>> FRAC_BITS;
        mim_sh  = mim >>> FRAC_BITS;
        nre_abs = nre[32] ? 33'(-nre) : 33'(nre);
        nim_abs = nim[32] ? 33'(-nim) : 33'(nim);
        if (r_s0_mode == MODE_ADD) begin
            c_re = clip16(34'(r_add_re));
            c_im = clip16(34'(r_add_im));
        end else begin
            c_re = clip16(34'(mre_sh));
            c_im = clip16(34'(mim_sh));
        end
        n_s1         = '0;
        n_s1.mode    = r_s0_mode;
        n_s1.fix_re  = c_re[15:0];
        n_s1.fix_im  = c_im[15:0];
        n_s1.fix_sat = c_re[16] | c_im[16];
        n_s1.neg_re  = nre[32];
        n_s1.neg_im  = nim[32];
        n_s1.rem_re  = RW'(nre_abs[31:0]) << FRAC_BITS;
        n_s1.rem_im  = RW'(nim_abs[31:0]) << FRAC_BITS;
        n_s1.den     = DENW'(r_bb_r) + DENW'(r_bb_i);
        n_s1.sq_rem  = SRW'(r_aa_r) + SRW'(r_aa_i);
        n_s1.dz      = (n_s1.den == '0);
    end

    // stage 2: quotient range check
    t_pipe n_s2;
    logic  r_s2_v;
    t_pipe r_s2;

    always_comb begin
        n_s2        = r_s1;
        n_s2.ovf_re = r_s1.rem_re >= (RW'(r_s1.den) << QBITS);
        n_s2.ovf_im = r_s1.rem_im >= (RW'(r_s1.den) << QBITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_ce) begin
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
        if (i_ce) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_v;
    assign o_pipe  = r_s2;

endmodule

// ===== hw/rtl/cau_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter
// pipelined restoring divider and digit-by-digit square root, one bit a stage
// ----------------------------------------------------------------------------
module cau_iter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  cau_pkg::t_pipe i_pipe,
    output logic           o_valid,
    output cau_pkg::t_pipe o_pipe
);
    import cau_pkg::*;

    logic  r_v [NSTEP];
    t_pipe r_p [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int K = NSTEP - 1 - s;
        t_pipe          src;
        t_pipe          n_p;
        logic           src_v;
        logic [RW-1:0]  sub;
        logic [SRW-1:0] trial;

        if (s == 0) begin : g_first
            assign src   = i_pipe;
            assign src_v = i_valid;
        end else begin : g_next
            assign src   = r_p[s-1];
            assign src_v = r_v[s-1];
        end

        always_comb begin
            n_p = src;
            sub = RW'(src.den) << K;
            if (src.rem_re >= sub) begin
                n_p.rem_re  = src.rem_re - sub;
                n_p.q_re[K] = 1'b1;
            end
            if (src.rem_im >= sub) begin
                n_p.rem_im  = src.rem_im - sub;
                n_p.q_im[K] = 1'b1;
            end
            trial = '0;
            if (K < ROOTW) begin
                trial = (SRW'(src.root) << (K + 1)) + (SRW'(1) << (2 * K));
                if (src.sq_rem >= trial) begin
                    n_p.sq_rem  = src.sq_rem - trial;
                    n_p.root[K % ROOTW] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_ce) begin
                r_v[s] <= src_v;
            end
            if (i_ce) begin
                r_p[s] <= n_p;
            end
        end
    end

    assign o_valid = r_v[NSTEP-1];
    assign o_pipe  = r_p[NSTEP-1];

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// add, multiply, divide and magnitude of signed fixed-point complex operands
// ----------------------------------------------------------------------------
// Takes one operand beat per clock while the output is not stalled and
// returns one result beat for each, in order, through three front stages
// (products, sums and range check), 17 stages of the shared divider and
// square-root pipeline (one quotient bit per stage, a root bit in all but
// the first) and the output register. The whole pipeline advances together;
// when a result waits at the output, input ready drops and nothing is lost.
// Results saturate to 16 bits and flag it; divide by zero gives zero with
// div_zero set.
module complex_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);
    import cau_pkg::*;

    // pipeline advance: output empty or being taken
    logic  ce;
    logic  f_v, it_v;
    t_pipe f_p, it_p;

    logic        r_o_v;
    logic [15:0] r_o_re, r_o_im;
    logic        r_o_dz, r_o_sat;

    logic [15:0] n_re, n_im;
    logic        n_dz, n_sat;
    logic [16:0] d_re, d_im;

    assign ce         = !r_o_v || o_out.ready;
    assign i_in.ready = ce;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in.valid),
        .i_mode  (i_in.mode),
        .i_a_re  (i_in.a_re),
        .i_a_im  (i_in.a_im),
        .i_b_re  (i_in.b_re),
        .i_b_im  (i_in.b_im),
        .o_valid (f_v),
        .o_pipe  (f_p)
    );

    cau_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_v),
        .i_pipe  (f_p),
        .o_valid (it_v),
        .o_pipe  (it_p)
    );

    // result selection by operation
    always_comb begin
        d_re  = div_fix(it_p.q_re, it_p.neg_re, it_p.ovf_re);
        d_im  = div_fix(it_p.q_im, it_p.neg_im, it_p.ovf_im);
        n_re  = it_p.fix_re;
        n_im  = it_p.fix_im;
        n_dz  = 1'b0;
        n_sat = it_p.fix_sat;
        unique case (it_p.mode)
            MODE_ADD, MODE_MUL: begin
            end
            MODE_DIV: begin
                if (it_p.dz) begin
                    n_re  = '0;
                    n_im  = '0;
                    n_dz  = 1'b1;
                    n_sat = 1'b0;
                end else begin
                    n_re  = d_re[15:0];
                    n_im  = d_im[15:0];
                    n_sat = d_re[16] | d_im[16];
                end
            end
            MODE_MAG: begin
                // root can reach 46340, clip to the positive limit
                n_sat = it_p.root[15];
                n_re  = it_p.root[15] ? 16'h7fff : it_p.root;
                n_im  = '0;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (ce) begin
            r_o_v <= it_v;
        end
        if (ce) begin
            r_o_re  <= n_re;
            r_o_im  <= n_im;
            r_o_dz  <= n_dz;
            r_o_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.res_re    = r_o_re;
    assign o_out.res_im    = r_o_im;
    assign o_out.div_zero  = r_o_dz;
    assign o_out.saturated = r_o_sat;

    // a stalled output holds the whole pipe
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while output stalled");

    // divide by zero gives a clean zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.div_zero |->
            !o_out.saturated && o_out.res_re == 16'sd0 && o_out.res_im == 16'sd0)
        else $error("divide by zero result not zero");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result beat after reset");

endmodule
